/* rtl/weighted_round_robin_task_switcher_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the weighted round-robin task switcher
// Clocked concurrent assertion wrappers; the enclosing module must
// provide clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_ROUND_ROBIN_TASK_SWITCHER_MACROS_SVH
`define WEIGHTED_ROUND_ROBIN_TASK_SWITCHER_MACROS_SVH

// checked only out of reset
`define WRRTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define WRRTS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/wrrts_pkg.sv */
// ----------------------------------------------------------------------------
// wrrts_pkg
// Shared constants and types of the weighted round-robin task switcher.
// ----------------------------------------------------------------------------
package wrrts_pkg;

    localparam int MAX_TASKS  = 16;
    localparam int SLOT_W     = $clog2(MAX_TASKS);
    localparam int COUNT_W    = $clog2(MAX_TASKS + 1);
    localparam int SP_W       = 64;
    localparam int QUANTUM_W  = 8;
    localparam int TASKNUM_W  = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = QUANTUM_W;

    localparam logic [QUANTUM_W-1:0] QUANTUM_HIGH_RESET = QUANTUM_W'(4);
    localparam logic [QUANTUM_W-1:0] QUANTUM_LOW_RESET  = QUANTUM_W'(1);

    typedef logic [SLOT_W-1:0] slot_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUANTUM_HIGH = 1'b0,
        CFG_QUANTUM_LOW  = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        MODE_TICK   = 1'b0,
        MODE_CREATE = 1'b1
    } mode_t;

    typedef enum logic [2:0] {
        ST_STAYED   = 3'd0,
        ST_SWITCHED = 3'd1,
        ST_CREATED  = 3'd2,
        ST_FAULT    = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    // slot table update from the scheduler
    typedef struct packed {
        logic            save_en;
        slot_t           save_slot;
        logic [SP_W-1:0] save_ptr;
        logic            add_en;
        slot_t           add_slot;
        slot_t           add_link;
        slot_t           add_after;
    } tbl_wr_t;

endpackage

/* rtl/wrrts_if.sv */
// ----------------------------------------------------------------------------
// wrrts_req_if / wrrts_rsp_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface wrrts_req_if import wrrts_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            mode;
    logic [SP_W-1:0] stack_pointer;

    modport source (output valid, output mode, output stack_pointer, input ready);
    modport sink   (input valid, input mode, input stack_pointer, output ready);
endinterface

interface wrrts_rsp_if import wrrts_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [SP_W-1:0]      resume_pointer;
    logic [TASKNUM_W-1:0] task_number;
    logic [2:0]           status;

    modport source (output valid, output resume_pointer, output task_number,
                    output status, input ready);
    modport sink   (input valid, input resume_pointer, input task_number,
                    input status, output ready);
endinterface

/* rtl/wrrts_slot_table.sv */
// ----------------------------------------------------------------------------
// wrrts_slot_table
// Per-slot saved stack pointer, ring link and priority class.
// ----------------------------------------------------------------------------
module wrrts_slot_table import wrrts_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  slot_t           link_addr,
    output slot_t           link_data,
    input  slot_t           ptr_addr,
    output logic [SP_W-1:0] ptr_data,
    input  slot_t           pri_addr,
    output logic            pri_data,
    input  tbl_wr_t         wr
);

    logic [SP_W-1:0] ptr_mem [MAX_TASKS];
    slot_t           link_reg [MAX_TASKS];
    logic            low_reg [MAX_TASKS];

    assign link_data = link_reg[link_addr];
    assign ptr_data  = ptr_mem[ptr_addr];
    assign pri_data  = low_reg[pri_addr];

    // pointers are undefined until written
    always_ff @(posedge clk)
    begin
        if (wr.save_en)
        begin
            ptr_mem[wr.save_slot] <= wr.save_ptr;
        end
    end

    // all links reset to slot zero, so slot zero rings to itself
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                link_reg[i] <= '0;
                low_reg[i]  <= 1'b0;
            end
        end
        else if (wr.add_en)
        begin
            link_reg[wr.add_slot]  <= wr.add_link;
            link_reg[wr.add_after] <= wr.add_slot;
            low_reg[wr.add_slot]   <= 1'b1;
        end
    end

endmodule

/* rtl/wrrts_sched.sv */
// ----------------------------------------------------------------------------
// wrrts_sched
// Current task, quantum countdown, task count and halt; decides each item
// in one pass and holds the result register.
// ----------------------------------------------------------------------------
`include "weighted_round_robin_task_switcher_macros.svh"

module wrrts_sched import wrrts_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 item_mode,
    input  logic [SP_W-1:0]      item_sp,
    output logic                 take,
    input  logic [QUANTUM_W-1:0] hi_quantum,
    input  logic [QUANTUM_W-1:0] lo_quantum,
    output slot_t                link_addr,
    input  slot_t                link_data,
    output slot_t                ptr_addr,
    input  logic [SP_W-1:0]      ptr_data,
    output slot_t                pri_addr,
    input  logic                 pri_data,
    output tbl_wr_t              tbl_wr,
    wrrts_rsp_if.source          result
);

    slot_t                cur_reg, cur_next;
    logic [QUANTUM_W-1:0] ticks_reg, ticks_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 halted_reg, halted_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SP_W-1:0]      out_ptr_reg, out_ptr_next;
    logic [TASKNUM_W-1:0] out_num_reg, out_num_next;
    status_t              out_st_reg, out_st_next;
    logic [SP_W-1:0]      switch_ptr;
    slot_t                new_slot;
    logic                 create_ok;

    assign take      = item_valid && (!out_valid_reg || result.ready);
    assign link_addr = cur_reg;
    assign ptr_addr  = link_data;
    assign pri_addr  = link_data;
    assign new_slot  = count_reg[SLOT_W-1:0];
    assign create_ok = !halted_reg && (item_mode == MODE_CREATE)
                       && (count_reg < COUNT_W'(MAX_TASKS));

    // single-task ring: the pointer being saved is the one resumed
    assign switch_ptr = (link_data == cur_reg) ? item_sp : ptr_data;

    always_comb
    begin
        cur_next     = cur_reg;
        ticks_next   = ticks_reg;
        count_next   = count_reg;
        halted_next  = halted_reg;
        out_ptr_next = '0;
        out_num_next = '0;
        out_st_next  = ST_FAULT;
        tbl_wr       = '0;

        if (halted_reg)
        begin
            out_st_next = ST_FAULT;
        end
        else if (item_mode == MODE_TICK)
        begin
            tbl_wr.save_en   = take;
            tbl_wr.save_slot = cur_reg;
            tbl_wr.save_ptr  = item_sp;
            if (ticks_reg > QUANTUM_W'(1))
            begin
                ticks_next   = ticks_reg - QUANTUM_W'(1);
                out_ptr_next = item_sp;
                out_num_next = TASKNUM_W'(cur_reg) + TASKNUM_W'(1);
                out_st_next  = ST_STAYED;
            end
            else
            begin
                cur_next     = link_data;
                ticks_next   = pri_data ? lo_quantum : hi_quantum;
                out_num_next = TASKNUM_W'(link_data) + TASKNUM_W'(1);
                if (switch_ptr == '0)
                begin
                    halted_next = 1'b1;
                    out_st_next = ST_FAULT;
                end
                else
                begin
                    out_ptr_next = switch_ptr;
                    out_st_next  = ST_SWITCHED;
                end
            end
        end
        else if (!create_ok)
        begin
            out_st_next = ST_FULL;
        end
        else
        begin
            tbl_wr.save_en   = take;
            tbl_wr.save_slot = new_slot;
            tbl_wr.save_ptr  = item_sp;
            tbl_wr.add_en    = take;
            tbl_wr.add_slot  = new_slot;
            tbl_wr.add_link  = link_data;
            tbl_wr.add_after = cur_reg;
            count_next       = count_reg + COUNT_W'(1);
            out_num_next     = TASKNUM_W'(new_slot) + TASKNUM_W'(1);
            out_st_next      = ST_CREATED;
        end
    end

    always_comb
    begin
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            ticks_reg     <= QUANTUM_HIGH_RESET;
            count_reg     <= COUNT_W'(1);
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                cur_reg    <= cur_next;
                ticks_reg  <= ticks_next;
                count_reg  <= count_next;
                halted_reg <= halted_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_ptr_reg <= out_ptr_next;
            out_num_reg <= out_num_next;
            out_st_reg  <= out_st_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.resume_pointer = out_ptr_reg;
    assign result.task_number    = out_num_reg;
    assign result.status         = out_st_reg;

    `WRRTS_ASSERT(a_halt_sticky, halted_reg |=> halted_reg, "halt cleared without reset")
    `WRRTS_ASSERT(a_count_range,
        (count_reg >= COUNT_W'(1)) && (count_reg <= COUNT_W'(MAX_TASKS)),
        "task count out of range")
    `WRRTS_ASSERT(a_cur_live, COUNT_W'(cur_reg) < count_reg, "current slot beyond live tasks")
    `WRRTS_ASSERT(a_count_only_create,
        !(take && create_ok) |=> $stable(count_reg),
        "task count moved without create")
    `WRRTS_ASSERT(a_halted_answer,
        (take && halted_reg) |=>
            (result.valid && out_st_reg == ST_FAULT && out_num_reg == '0),
        "halted item not answered as fault")

endmodule

/* rtl/weighted_round_robin_task_switcher.sv */
// ----------------------------------------------------------------------------
// weighted_round_robin_task_switcher
// Ring of task slots scheduled by weighted round-robin time slices.
// ----------------------------------------------------------------------------
// One item enters per cycle while the result side does not stall; each result
// passes the input register, then the result register, with the single-pass
// update of the slot table and the current-task registers between the two. A
// tick saves the running stack pointer, counts down the quantum and, when spent,
// moves to the next slot of the ring; a create links a low-priority slot after
// the current one. A null pointer on a switch halts the block until reset. The
// user must write the two quantum registers only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module weighted_round_robin_task_switcher import wrrts_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    wrrts_req_if.sink             request,
    wrrts_rsp_if.source           result
);

    logic                 in_valid_reg;
    logic                 in_mode_reg;
    logic [SP_W-1:0]      in_sp_reg;
    logic [QUANTUM_W-1:0] qhigh_reg;
    logic [QUANTUM_W-1:0] qlow_reg;
    logic                 take;
    slot_t                link_addr, link_data, ptr_addr, pri_addr;
    logic [SP_W-1:0]      ptr_data;
    logic                 pri_data;
    tbl_wr_t              tbl_wr;

    assign request.ready = !in_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (request.ready)
        begin
            in_valid_reg <= request.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            in_mode_reg <= request.mode;
            in_sp_reg   <= request.stack_pointer;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qhigh_reg <= QUANTUM_HIGH_RESET;
            qlow_reg  <= QUANTUM_LOW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_QUANTUM_HIGH: qhigh_reg <= cfg_data;
                CFG_QUANTUM_LOW:  qlow_reg  <= cfg_data;
                default:          qhigh_reg <= qhigh_reg;
            endcase
        end
    end

    wrrts_slot_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .link_addr (link_addr),
        .link_data (link_data),
        .ptr_addr  (ptr_addr),
        .ptr_data  (ptr_data),
        .pri_addr  (pri_addr),
        .pri_data  (pri_data),
        .wr        (tbl_wr)
    );

    wrrts_sched u_sched (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (in_valid_reg),
        .item_mode    (in_mode_reg),
        .item_sp      (in_sp_reg),
        .take         (take),
        .hi_quantum   (qhigh_reg),
        .lo_quantum   (qlow_reg),
        .link_addr    (link_addr),
        .link_data    (link_data),
        .ptr_addr     (ptr_addr),
        .ptr_data     (ptr_data),
        .pri_addr     (pri_addr),
        .pri_data     (pri_data),
        .tbl_wr       (tbl_wr),
        .result       (result)
    );

endmodule

/* test/tb_weighted_round_robin_task_switcher.sv */
// ----------------------------------------------------------------------------
// tb_weighted_round_robin_task_switcher
// Drives tick and create items into the task switcher and checks every
// result against a scheduler model kept in the bench. The model tracks the
// slot ring, the quanta and the halt flag. The run covers several quantum
// settings, a long result-side stall, a back-to-back stretch, and it ends
// with a full table and a null-pointer halt.
// ----------------------------------------------------------------------------
module tb_weighted_round_robin_task_switcher import wrrts_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_STALL = 300;

    typedef struct packed {
        logic [SP_W-1:0]      resume_pointer;
        logic [TASKNUM_W-1:0] task_number;
        status_t              status;
    } switch_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wrrts_req_if req_ch ();
    wrrts_rsp_if res_ch ();

    weighted_round_robin_task_switcher DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (req_ch),
        .result    (res_ch)
    );

    // scheduler model state
    logic [SP_W-1:0]      ring_pointer [MAX_TASKS];
    slot_t                ring_link [MAX_TASKS];
    logic                 ring_low [MAX_TASKS];
    slot_t                cur_slot;
    logic [QUANTUM_W-1:0] model_ticks;
    logic [COUNT_W-1:0]   live_tasks;
    logic                 sched_halted;
    logic [QUANTUM_W-1:0] hi_quantum_cfg;
    logic [QUANTUM_W-1:0] lo_quantum_cfg;

    switch_result_t awaited_switches [$];
    switch_result_t head_result;
    int             mismatch_count = 0;
    bit             idle_on = 1'b1;
    bit             stall_request = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic switch_result_t predict_switch(input mode_t m,
                                                      input logic [SP_W-1:0] sp);
        switch_result_t r;
        slot_t          nxt;
        slot_t          fresh;
        r = '{resume_pointer: '0, task_number: '0, status: ST_FAULT};
        if (sched_halted)
        begin
            return r;
        end
        if (m == MODE_TICK)
        begin
            ring_pointer[cur_slot] = sp;
            if (model_ticks > 1)
            begin
                model_ticks = model_ticks - 1'b1;
                r.resume_pointer = sp;
                r.task_number = TASKNUM_W'(cur_slot) + TASKNUM_W'(1);
                r.status = ST_STAYED;
            end
            else
            begin
                nxt = ring_link[cur_slot];
                cur_slot = nxt;
                model_ticks = ring_low[nxt] ? lo_quantum_cfg : hi_quantum_cfg;
                r.task_number = TASKNUM_W'(nxt) + TASKNUM_W'(1);
                if (ring_pointer[nxt] == '0)
                begin
                    sched_halted = 1'b1;
                end
                else
                begin
                    r.resume_pointer = ring_pointer[nxt];
                    r.status = ST_SWITCHED;
                end
            end
        end
        else if (live_tasks >= MAX_TASKS)
        begin
            r.status = ST_FULL;
        end
        else
        begin
            fresh = slot_t'(live_tasks);
            ring_pointer[fresh] = sp;
            ring_low[fresh] = 1'b1;
            ring_link[fresh] = ring_link[cur_slot];
            ring_link[cur_slot] = fresh;
            live_tasks = live_tasks + 1'b1;
            r.task_number = TASKNUM_W'(fresh) + TASKNUM_W'(1);
            r.status = ST_CREATED;
        end
        return r;
    endfunction

    function automatic logic [SP_W-1:0] nonzero_pointer();
        return {$urandom(), $urandom()} | SP_W'(1);
    endfunction

    function automatic logic [SP_W-1:0] random_pointer();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return SP_W'(1) << $urandom_range(0, SP_W - 1);
            3: return SP_W'($urandom_range(1, 255));
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic send_item(input mode_t m, input logic [SP_W-1:0] sp);
        req_ch.valid <= 1'b1;
        req_ch.mode <= m;
        req_ch.stack_pointer <= sp;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        awaited_switches.push_back(predict_switch(m, sp));
    endtask

    // a null pointer is kept off any tick that switches and off every create
    task automatic random_item(input bit gaps);
        mode_t           m;
        logic [SP_W-1:0] sp;
        m = MODE_TICK;
        if (live_tasks < MAX_TASKS - 1 && $urandom_range(0, 23) == 0)
        begin
            m = MODE_CREATE;
        end
        sp = random_pointer();
        if (sp == '0 && (m == MODE_CREATE || model_ticks <= 1))
        begin
            sp = nonzero_pointer();
        end
        if (gaps && idle_on && $urandom_range(0, 7) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        send_item(m, sp);
    endtask

    task automatic wait_quiet();
        req_ch.valid <= 1'b0;
        while (awaited_switches.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_quanta(input logic [QUANTUM_W-1:0] high,
                              input logic [QUANTUM_W-1:0] low);
        cfg_we <= 1'b1;
        cfg_index <= CFG_QUANTUM_HIGH;
        cfg_data <= high;
        @(posedge clk);
        cfg_index <= CFG_QUANTUM_LOW;
        cfg_data <= low;
        @(posedge clk);
        cfg_we <= 1'b0;
        hi_quantum_cfg = high;
        lo_quantum_cfg = low;
    endtask

    task automatic test_directed();
        send_item(MODE_TICK, '1);
        send_item(MODE_TICK, '0);
        send_item(MODE_TICK, 64'h1);
        // quantum spent with a single task: switches back to itself
        send_item(MODE_TICK, 64'h8000_0000_0000_0000);
        send_item(MODE_CREATE, '1);
        send_item(MODE_CREATE, 64'h5555_5555_5555_5555);
        repeat (4) send_item(MODE_TICK, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(MODE_TICK, 64'h0123_4567_89AB_CDEF);
        send_item(MODE_CREATE, 64'h1);
        repeat (3) send_item(MODE_TICK, nonzero_pointer());
    endtask

    task automatic test_weighted_phases();
        int p;
        int n;
        for (p = 0; p < 6; p++)
        begin
            wait_quiet();
            case (p)
                0: set_quanta(8'd1, 8'd1);
                1: set_quanta(8'd255, 8'd1);
                2: set_quanta(8'd1, 8'd255);
                3: set_quanta(8'd254, 8'd2);
                default: set_quanta(QUANTUM_W'($urandom_range(1, 255)),
                                    QUANTUM_W'($urandom_range(1, 16)));
            endcase
            for (n = 0; n < 180; n++)
            begin
                random_item(1'b1);
            end
        end
    endtask

    task automatic test_input_backpressure();
        int n;
        wait_quiet();
        stall_request = 1'b1;
        for (n = 0; n < 40; n++)
        begin
            random_item(1'b0);
        end
    endtask

    task automatic test_back_to_back();
        int n;
        wait_quiet();
        set_quanta(QUANTUM_W'($urandom_range(1, 8)), QUANTUM_W'($urandom_range(1, 8)));
        for (n = 0; n < 150; n++)
        begin
            random_item(1'b0);
        end
    endtask

    task automatic test_full_table_and_fault();
        wait_quiet();
        set_quanta(8'd1, 8'd1);
        while (live_tasks < MAX_TASKS - 1)
        begin
            send_item(MODE_CREATE, nonzero_pointer());
        end
        // null initial pointer is accepted, faults once switched to
        send_item(MODE_CREATE, '0);
        send_item(MODE_CREATE, '1);
        send_item(MODE_CREATE, '0);
        while (!sched_halted)
        begin
            send_item(MODE_TICK, nonzero_pointer());
        end
        send_item(MODE_TICK, '0);
        send_item(MODE_CREATE, '1);
        send_item(MODE_TICK, '1);
        send_item(MODE_CREATE, '0);
    endtask

    initial
    begin : result_receiver
        int held;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_request)
            begin
                res_ch.ready <= 1'b0;
                for (held = 0; held < LONG_STALL; held++)
                begin
                    @(posedge clk);
                end
                res_ch.ready <= 1'b1;
                stall_request = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (awaited_switches.size() == 0)
            begin
                $error("unexpected result item: resume_pointer %h task_number %0d status %0d",
                       res_ch.resume_pointer, res_ch.task_number, res_ch.status);
                mismatch_count++;
            end
            else
            begin
                head_result = awaited_switches.pop_front();
                if (res_ch.resume_pointer !== head_result.resume_pointer)
                begin
                    $error("resume_pointer: expected %h, actual %h",
                           head_result.resume_pointer, res_ch.resume_pointer);
                    mismatch_count++;
                end
                if (res_ch.task_number !== head_result.task_number)
                begin
                    $error("task_number: expected %0d, actual %0d",
                           head_result.task_number, res_ch.task_number);
                    mismatch_count++;
                end
                if (res_ch.status !== head_result.status)
                begin
                    $error("status: expected %0d, actual %0d",
                           head_result.status, res_ch.status);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #6_000_000;
        $display("[weighted_round_robin_task_switcher] ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_QUANTUM_HIGH;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_TICK;
        req_ch.stack_pointer = '0;
        for (int s = 0; s < MAX_TASKS; s++)
        begin
            ring_pointer[s] = '0;
            ring_link[s] = '0;
            ring_low[s] = 1'b0;
        end
        cur_slot = '0;
        hi_quantum_cfg = QUANTUM_HIGH_RESET;
        lo_quantum_cfg = QUANTUM_LOW_RESET;
        model_ticks = QUANTUM_HIGH_RESET;
        live_tasks = COUNT_W'(1);
        sched_halted = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_weighted_phases();
        test_input_backpressure();
        idle_on = 1'b0;
        test_back_to_back();
        test_full_table_and_fault();
        wait_quiet();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("[weighted_round_robin_task_switcher] OK");
        end
        else
        begin
            $display("[weighted_round_robin_task_switcher] ERROR");
        end
        $finish;
    end

endmodule
